// File: sv/bblc_pkg.sv
// Shared types and constants for the block buffer LRU cache.
// Used by bblc_seq and block_buffer_lru_cache; depends on nothing else.
package bblc_pkg;

    localparam int BBLC_NUM_SLOTS = 16;
    localparam int BLOCK_W        = 32;
    localparam int SLOT_W         = 4;

    // One request as captured from the input channel.
    typedef struct packed {
        logic [BLOCK_W-1:0] disk_block;
        logic               mark_dirty;
    } req_t;

    // One result item as handed to the output register.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               fill_needed;
        logic               writeback_needed;
        logic [BLOCK_W-1:0] victim_block;
    } res_t;

endpackage

// File: sv/bblc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instanced by bblc_seq for the tag and recency stores.
module bblc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/bblc_seq.sv
// Sequencer and datapath of the cache: tag scan, recency scan and shift.
// Depends on bblc_pkg and bblc_ram.
module bblc_seq #(
    parameter int NUM_SLOTS = bblc_pkg::BBLC_NUM_SLOTS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bblc_pkg::req_t req,
    output logic          ready,
    output logic          res_valid,
    input  logic          res_take,
    output bblc_pkg::res_t res
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int BW = bblc_pkg::BLOCK_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_TSCAN  = 8'b0000_0010,
        ST_OSCAN  = 8'b0000_0100,
        ST_VREAD  = 8'b0000_1000,
        ST_VTAG   = 8'b0001_0000,
        ST_SHIFT  = 8'b0010_0000,
        ST_FINISH = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [IW-1:0]  slot_reg, slot_next;
    logic           hit_reg, hit_next;
    logic           wb_reg, wb_next;
    logic [BW-1:0]  victim_reg, victim_next;
    logic [BW-1:0]  key_reg, key_next;
    logic           md_reg, md_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] dirty_reg, dirty_next;

    logic           tag_we;
    logic [IW-1:0]  tag_waddr, tag_raddr;
    logic [BW-1:0]  tag_rdata;
    logic           ord_we;
    logic [IW-1:0]  ord_waddr, ord_raddr, ord_wdata;
    logic [IW-1:0]  ord_rdata;

    logic [CW-1:0]  cnt_dec, cnt_inc, used_dec;
    logic [IW-1:0]  prev_idx;
    logic           tag_match;

    bblc_ram #(.WIDTH(BW), .DEPTH(NUM_SLOTS)) u_tags (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (key_reg),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    bblc_ram #(.WIDTH(IW), .DEPTH(NUM_SLOTS)) u_order (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    assign cnt_dec  = cnt_reg - CW'(1);
    assign cnt_inc  = cnt_reg + CW'(1);
    assign used_dec = used_reg - CW'(1);
    assign prev_idx = cnt_dec[IW-1:0];

    // The one comparator of the tag scan; it looks at the entry read last cycle.
    assign tag_match = (cnt_reg != '0) && valid_reg[prev_idx] && (tag_rdata == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        used_next   = used_reg;
        slot_next   = slot_reg;
        hit_next    = hit_reg;
        wb_next     = wb_reg;
        victim_next = victim_reg;
        key_next    = key_reg;
        md_next     = md_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        tag_we      = 1'b0;
        tag_waddr   = slot_reg;
        tag_raddr   = cnt_reg[IW-1:0];
        ord_we      = 1'b0;
        ord_waddr   = prev_idx;
        ord_wdata   = ord_rdata;
        ord_raddr   = cnt_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next    = req.disk_block;
                    md_next     = req.mark_dirty;
                    cnt_next    = '0;
                    hit_next    = 1'b0;
                    wb_next     = 1'b0;
                    victim_next = '0;
                    state_next  = ST_TSCAN;
                end
            end
            ST_TSCAN:
            begin
                if (tag_match)
                begin
                    hit_next   = 1'b1;
                    slot_next  = prev_idx;
                    cnt_next   = '0;
                    state_next = ST_OSCAN;
                end
                else if (cnt_reg == CW'(NUM_SLOTS))
                begin
                    if (used_reg != CW'(NUM_SLOTS))
                    begin
                        // A slot that has never been used is taken first.
                        slot_next  = used_reg[IW-1:0];
                        used_next  = used_reg + CW'(1);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ord_raddr  = '0;
                        state_next = ST_VREAD;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            ST_OSCAN:
            begin
                if ((cnt_reg != '0) && (ord_rdata == slot_reg))
                begin
                    // The read of the next position is already in flight.
                    state_next = ST_SHIFT;
                end
                else if (cnt_reg == used_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            ST_VREAD:
            begin
                slot_next  = ord_rdata;
                tag_raddr  = ord_rdata;
                state_next = ST_VTAG;
            end
            ST_VTAG:
            begin
                wb_next     = dirty_reg[slot_reg];
                victim_next = dirty_reg[slot_reg] ? tag_rdata : '0;
                ord_raddr   = IW'(1);
                cnt_next    = CW'(1);
                state_next  = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (cnt_reg < used_reg)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = prev_idx;
                    ord_wdata = ord_rdata;
                    ord_raddr = cnt_inc[IW-1:0];
                    cnt_next  = cnt_inc;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                ord_we    = 1'b1;
                ord_waddr = used_dec[IW-1:0];
                ord_wdata = slot_reg;
                if (hit_reg)
                begin
                    dirty_next[slot_reg] = dirty_reg[slot_reg] | md_reg;
                end
                else
                begin
                    tag_we               = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    dirty_next[slot_reg] = md_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        slot_reg   <= slot_next;
        hit_reg    <= hit_next;
        wb_reg     <= wb_next;
        victim_reg <= victim_next;
        key_reg    <= key_next;
        md_reg     <= md_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.slot             = bblc_pkg::SLOT_W'(slot_reg);
        res.hit              = hit_reg;
        res.fill_needed      = ~hit_reg;
        res.writeback_needed = wb_reg;
        res.victim_block     = victim_reg;
    end

endmodule

// File: sv/block_buffer_lru_cache.sv
// Top level of the block buffer LRU cache: handshakes and the output register.
// Depends on bblc_pkg, bblc_seq and bblc_ram.
//
// Each input item names a disk block (disk_block) and says whether the caller
// will modify it (mark_dirty). The block answers every item with exactly one
// result item: the slot that now holds the block, hit or fill_needed, and on
// eviction of a dirty slot writeback_needed with the victim's block number.
// Both channels use valid and stall; an item moves on a rising edge where
// valid is high and stall is low.
// The sequencer works on one item at a time, so in_stall stays high from the
// edge that accepts an item until its result has entered the output register.
// The cost is set by one tag comparator and one recency RAM port: a tag scan that
// stops at the first match and otherwise covers all NUM_SLOTS tags, then on a
// hit a scan for the slot in the recency order, and on a hit or eviction a shift
// of that order, one entry a cycle. The sequencer is ready for the next item from
// the edge that loads the result into the output register. Items follow fastest
// on a hit on slot 0 with one slot in use, slower on a miss into a fresh slot and
// slowest on an eviction or a hit on the last slot of a full cache.
// Reset empties the cache at once: all slots invalid and clean, none used.
// If the receiver stalls, the result waits in the output register and the
// next result is held in the sequencer until the register is free.
module block_buffer_lru_cache #(
    parameter int NUM_SLOTS = bblc_pkg::BBLC_NUM_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bblc_pkg::BLOCK_W-1:0] disk_block,
    input  logic                         mark_dirty,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bblc_pkg::SLOT_W-1:0]  slot,
    output logic                         hit,
    output logic                         fill_needed,
    output logic                         writeback_needed,
    output logic [bblc_pkg::BLOCK_W-1:0] victim_block
);

    bblc_pkg::req_t req;
    bblc_pkg::res_t res;
    bblc_pkg::res_t out_reg;
    logic           out_valid_reg;
    logic           seq_ready;
    logic           res_valid;
    logic           out_free;
    logic           start;

    // The sequencer takes a new item only when it is idle.
    assign in_stall = ~seq_ready;
    assign start    = in_valid & seq_ready;

    always_comb
    begin
        req.disk_block = disk_block;
        req.mark_dirty = mark_dirty;
    end

    // The output register can take a result when it is empty or being drained.
    assign out_free = ~out_valid_reg | ~out_stall;

    bblc_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .ready     (seq_ready),
        .res_valid (res_valid),
        .res_take  (out_free),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign slot             = out_reg.slot;
    assign hit              = out_reg.hit;
    assign fill_needed      = out_reg.fill_needed;
    assign writeback_needed = out_reg.writeback_needed;
    assign victim_block     = out_reg.victim_block;

endmodule
